>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define HWS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next.
`define HWS_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

>>> hdl/hws_pkg.sv
`default_nettype none

package hws_pkg;

   localparam int NUM_BUCKETS = 24;
   localparam int IDX_W       = $clog2(NUM_BUCKETS);
   // room for ring position plus a 5 bit age without overflow
   localparam int SUM_W       = ((IDX_W > 5) ? IDX_W : 5) + 2;

   typedef enum logic [1:0] {
      CMD_RECORD = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [31:0] query_count;
      logic [31:0] block_count;
      logic [63:0] resp_sum;
      logic [63:0] proc_sum;
   } bucket_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      bucket_type       data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

endpackage

`default_nettype wire

>>> hdl/hws_bucket_ram.sv
`default_nettype none

module hws_bucket_ram
   import hws_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire ram_wr_type wr,
   input  wire ram_rd_type rd,
   output      bucket_type rd_data
);

   bucket_type             mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] valid_ff;
   logic [NUM_BUCKETS-1:0] valid_in;
   bucket_type             rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // entries never written since reset read as an empty bucket
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= valid_ff[rd.addr] ? mem[rd.addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/hourly_window_stats_core.sv
// Channel | Dir | Payload
// req_    | in  | tuser: cmd; tdata: was_blocked, resolve_time, process_time, bucket_age
// rsp_    | out | tdata: window totals, bucket read fields, hour_index
//
// Takes one item per cycle while rsp_ is not stalled; its result is registered onto rsp_
// after the bucket RAM read at the accepting edge and then the update stage.
// A write to the entry read by the next item is forwarded from a last-write register.
// Reset is synchronous; per-entry valid bits empty every bucket at once, no clearing pass.
// A stalled rsp_ holds the update stage and drops req_tready in the same cycle.
`default_nettype none

module hourly_window_stats_core
   import hws_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // [0] was_blocked, [32:1] resolve_time, [64:33] process_time, [69:65] bucket_age
   input  wire logic [71:0]  req_tdata,
   // [1:0] cmd
   input  wire logic [1:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] sum_queries, [63:32] sum_blocked, [127:64] sum_response_time,
   // [191:128] sum_process_time, [223:192] read_queries, [255:224] read_blocked,
   // [319:256] read_response_time, [324:320] hour_index
   output      logic [327:0] rsp_tdata
);

   `include "assert_macros.svh"

   // input fields
   cmd_type     in_cmd;
   logic        in_blk;
   logic [31:0] in_rt;
   logic [31:0] in_pt;
   logic [4:0]  in_age;

   assign in_cmd = cmd_type'(req_tuser);
   assign in_blk = req_tdata[0];
   assign in_rt  = req_tdata[32:1];
   assign in_pt  = req_tdata[64:33];
   assign in_age = req_tdata[69:65];

   logic advance;
   logic accept;
   logic commit;

   // issue stage
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] pos_inc;
   logic [SUM_W-1:0] age_sum;
   logic             age_ok;
   logic [IDX_W-1:0] rd_addr;

   // update stage
   logic             s1_vld_ff, s1_vld_in;
   cmd_type          s1_cmd_ff;
   logic             s1_blk_ff;
   logic [32:0]      s1_resp_ff;
   logic [31:0]      s1_pt_ff;
   logic [IDX_W-1:0] s1_addr_ff;
   logic             s1_rd_ok_ff;
   logic [4:0]       s1_hour_ff;

   // last write, for forwarding
   logic             lw_en_ff, lw_en_in;
   logic [IDX_W-1:0] lw_addr_ff;
   bucket_type       lw_data_ff;

   bucket_type  ram_q;
   bucket_type  cur;
   bucket_type  upd;
   logic        upd_wr;
   ram_wr_type  wr;
   ram_rd_type  rd;

   logic [31:0] tot_q_ff, tot_q_in;
   logic [31:0] tot_b_ff, tot_b_in;
   logic [63:0] tot_r_ff, tot_r_in;
   logic [63:0] tot_p_ff, tot_p_in;

   logic         rsp_vld_ff, rsp_vld_in;
   logic [327:0] rsp_data_ff;
   logic [127:0] rd_fields;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign commit     = advance && s1_vld_ff;

   // ---------------- issue ----------------
   assign pos_inc = (pos_ff == IDX_W'(NUM_BUCKETS - 1)) ? '0 : pos_ff + 1'b1;
   assign age_sum = SUM_W'(pos_inc) + SUM_W'(in_age);
   assign age_ok  = SUM_W'(in_age) < SUM_W'(NUM_BUCKETS);

   always_comb begin
      unique case (in_cmd)
         CMD_RECORD: rd_addr = pos_ff;
         CMD_TICK:   rd_addr = pos_inc;
         default: begin
            if (age_sum >= SUM_W'(NUM_BUCKETS)) begin
               rd_addr = IDX_W'(age_sum - SUM_W'(NUM_BUCKETS));
            end else begin
               rd_addr = IDX_W'(age_sum);
            end
         end
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept && in_cmd == CMD_TICK) begin
         pos_in = pos_inc;
      end
   end

   assign rd.en   = accept;
   assign rd.addr = rd_addr;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (advance) begin
         s1_vld_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= in_cmd;
         s1_blk_ff   <= in_blk;
         s1_resp_ff  <= {1'b0, in_rt} + {1'b0, in_pt};
         s1_pt_ff    <= in_pt;
         s1_addr_ff  <= rd_addr;
         s1_rd_ok_ff <= (in_cmd == CMD_READ) && age_ok;
         s1_hour_ff  <= SUM_W'(pos_in) >> 0 == '0 ? 5'd0 : 5'(SUM_W'(pos_in));
      end
   end

   hws_bucket_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (ram_q)
   );

   // ---------------- update ----------------
   assign cur = (lw_en_ff && lw_addr_ff == s1_addr_ff) ? lw_data_ff : ram_q;

   always_comb begin
      upd      = cur;
      upd_wr   = 1'b0;
      tot_q_in = tot_q_ff;
      tot_b_in = tot_b_ff;
      tot_r_in = tot_r_ff;
      tot_p_in = tot_p_ff;
      if (commit) begin
         unique case (s1_cmd_ff)
            CMD_RECORD: begin
               upd_wr           = 1'b1;
               upd.query_count  = cur.query_count + 32'd1;
               upd.block_count  = cur.block_count + 32'(s1_blk_ff);
               upd.resp_sum     = cur.resp_sum + 64'(s1_resp_ff);
               upd.proc_sum     = cur.proc_sum + 64'(s1_pt_ff);
               tot_q_in         = tot_q_ff + 32'd1;
               tot_b_in         = tot_b_ff + 32'(s1_blk_ff);
               tot_r_in         = tot_r_ff + 64'(s1_resp_ff);
               tot_p_in         = tot_p_ff + 64'(s1_pt_ff);
            end
            CMD_TICK: begin
               upd_wr   = 1'b1;
               upd      = '0;
               tot_q_in = tot_q_ff - cur.query_count;
               tot_b_in = tot_b_ff - cur.block_count;
               tot_r_in = tot_r_ff - cur.resp_sum;
               tot_p_in = tot_p_ff - cur.proc_sum;
            end
            default: begin
               upd_wr = 1'b0;
            end
         endcase
      end
   end

   assign wr.en   = upd_wr;
   assign wr.addr = s1_addr_ff;
   assign wr.data = upd;

   always_comb begin
      lw_en_in = lw_en_ff;
      if (upd_wr) begin
         lw_en_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_en_ff <= 1'b0;
         tot_q_ff <= '0;
         tot_b_ff <= '0;
         tot_r_ff <= '0;
         tot_p_ff <= '0;
      end else begin
         lw_en_ff <= lw_en_in;
         tot_q_ff <= tot_q_in;
         tot_b_ff <= tot_b_in;
         tot_r_ff <= tot_r_in;
         tot_p_ff <= tot_p_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_wr) begin
         lw_addr_ff <= s1_addr_ff;
         lw_data_ff <= upd;
      end
   end

   // ---------------- output register ----------------
   assign rd_fields = s1_rd_ok_ff ? {cur.resp_sum, cur.block_count, cur.query_count} : '0;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= {3'd0, s1_hour_ff, rd_fields, tot_p_in, tot_r_in, tot_b_in, tot_q_in};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- checks ----------------
   `HWS_ASSERT(a_pos_range, pos_ff < IDX_W'(NUM_BUCKETS), "ring position out of range")
   `HWS_ASSERT_NEXT(a_tick_moves, accept && in_cmd == CMD_TICK, pos_ff != $past(pos_ff), "tick did not advance ring")
   `HWS_ASSERT_NEXT(a_tick_clears, commit && s1_cmd_ff == CMD_TICK, lw_en_ff && lw_data_ff == '0, "tick left bucket nonzero")
   `HWS_ASSERT(a_stall_full, (s1_vld_ff && !advance) |-> rsp_vld_ff, "update stage held with empty output")

endmodule

`default_nettype wire
